/* sv/lira_pkg.sv */
`default_nettype none

package lira_pkg;

  // Field widths fixed by the item format.
  localparam int LABEL_W     = 6;
  localparam int DEPTH_W     = 16;
  localparam int MASK_W      = 3;
  localparam int FUNC_W      = 2;
  localparam int WIDTH_W     = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH     = 1'b0;
  localparam logic REG_DEPTH_THRESHOLD = 1'b1;

  // Neighbor positions, also the bit order of the masks.
  localparam int NB_UP     = 0;
  localparam int NB_LEFT   = 1;
  localparam int NB_UPLEFT = 2;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               valid;
    logic [LABEL_W-1:0] label;
  } pix_t;

  typedef struct packed {
    logic [FUNC_W-1:0]              func;
    logic [MASK_W-1:0]              border;
    logic [MASK_W-1:0]              close_m;
    logic [LABEL_W-1:0]             label;
    logic [MASK_W-1:0][LABEL_W-1:0] nb_label;
    logic [LABEL_W-1:0]             query_a;
    logic [LABEL_W-1:0]             query_b;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   avail;
    entry_t entry;
  } head_t;

  function automatic logic label_in_range(input logic [LABEL_W-1:0] lab, input int max_regions);
    return {1'b0, lab} < (LABEL_W+1)'(max_regions);
  endfunction

endpackage

`default_nettype wire

/* sv/lira_ram.sv */
`default_nettype none

module lira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/lira_front.sv */
`default_nettype none

module lira_front #(
  parameter int MAX_REGIONS = 64,
  parameter int MAX_WIDTH   = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [lira_pkg::FUNC_W-1:0]     func,
  input  wire logic                            label_valid,
  input  wire logic [lira_pkg::LABEL_W-1:0]    label,
  input  wire logic [lira_pkg::DEPTH_W-1:0]    depth_mm,
  input  wire logic [lira_pkg::LABEL_W-1:0]    query_a,
  input  wire logic [lira_pkg::LABEL_W-1:0]    query_b,
  input  wire logic [lira_pkg::WIDTH_W-1:0]    image_width,
  input  wire logic [lira_pkg::DEPTH_W-1:0]    depth_threshold_mm,
  input  wire logic                            q_full,
  output lira_pkg::push_t                      q_push
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CW    = (COL_W + 1 > lira_pkg::WIDTH_W) ? COL_W + 1 : lira_pkg::WIDTH_W;
  localparam int PIX_W = $bits(lira_pkg::pix_t);

  // Raster position.
  logic [COL_W-1:0] column_count;
  logic             first_row;

  // Compare stage.
  logic                          f1_valid;
  logic [lira_pkg::FUNC_W-1:0]   f1_func;
  lira_pkg::pix_t                f1_pix;
  logic                          f1_first;
  logic [COL_W-1:0]              f1_col;
  logic                          f1_row_end;
  logic [lira_pkg::LABEL_W-1:0]  f1_qa;
  logic [lira_pkg::LABEL_W-1:0]  f1_qb;
  logic                          f1_done;
  logic                          f1_pixel;

  lira_pkg::pix_t left_pix;
  lira_pkg::pix_t ul_pix;
  lira_pkg::pix_t up_pix;

  logic                 accept;
  logic [CW-1:0]        w_ext;
  logic [CW-1:0]        w_eff;
  logic                 row_end;
  logic                 lab_ok;
  lira_pkg::pix_t       cur_in;

  logic                 line_re;
  logic                 line_we;
  logic [PIX_W-1:0]     line_rdata;
  logic                 lfwd_hit;
  lira_pkg::pix_t       lfwd_data;

  lira_pkg::pix_t                  nb [lira_pkg::MASK_W];
  logic [lira_pkg::MASK_W-1:0]     present;
  logic [lira_pkg::MASK_W-1:0]     hit;
  logic [lira_pkg::MASK_W-1:0]     near;
  logic [lira_pkg::DEPTH_W-1:0]    diff [lira_pkg::MASK_W];

  assign accept   = push && !full;
  assign full     = f1_valid && q_full;
  assign f1_done  = f1_valid && !q_full;
  assign f1_pixel = (f1_func == lira_pkg::FUNC_PIXEL);

  // Effective row width: zero acts as one, anything above the line store as its size.
  assign w_ext = CW'(image_width);
  assign w_eff = (w_ext == '0) ? CW'(1) : ((w_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_ext);
  assign row_end = (CW'(column_count) + CW'(1)) >= w_eff;

  assign lab_ok       = label_valid && lira_pkg::label_in_range(label, MAX_REGIONS);
  assign cur_in.depth = depth_mm;
  assign cur_in.valid = lab_ok;
  assign cur_in.label = lab_ok ? label : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
    end else if (accept && func == lira_pkg::FUNC_PIXEL) begin
      if (row_end) begin
        column_count <= '0;
        first_row    <= 1'b0;
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end else if (accept && func == lira_pkg::FUNC_START) begin
      column_count <= '0;
      first_row    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (f1_done) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_func    <= func;
      f1_pix     <= cur_in;
      f1_first   <= first_row;
      f1_col     <= column_count;
      f1_row_end <= row_end;
      f1_qa      <= query_a;
      f1_qb      <= query_b;
    end
  end

  // Line store: read the upper neighbor on accept, write the pixel back when it leaves.
  assign line_re = accept && (func == lira_pkg::FUNC_PIXEL);
  assign line_we = f1_done && f1_pixel;

  lira_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (line_we),
    .waddr(f1_col),
    .wdata(f1_pix),
    .re   (line_re),
    .raddr(column_count),
    .rdata(line_rdata)
  );

  // A write landing on the edge that captures a read of the same column is forwarded.
  always_ff @(posedge clk) begin
    if (rst) begin
      lfwd_hit <= 1'b0;
    end else if (accept) begin
      lfwd_hit <= line_we && (f1_col == column_count);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lfwd_data <= f1_pix;
    end
  end

  assign up_pix = lfwd_hit ? lfwd_data : lira_pkg::pix_t'(line_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pix <= '0;
      ul_pix   <= '0;
    end else if (f1_done && f1_pixel) begin
      left_pix <= f1_row_end ? '0 : f1_pix;
      ul_pix   <= (f1_row_end || f1_first) ? '0 : up_pix;
    end else if (f1_done && f1_func == lira_pkg::FUNC_START) begin
      left_pix <= '0;
      ul_pix   <= '0;
    end
  end

  assign nb[lira_pkg::NB_UP]     = up_pix;
  assign nb[lira_pkg::NB_LEFT]   = left_pix;
  assign nb[lira_pkg::NB_UPLEFT] = ul_pix;

  assign present[lira_pkg::NB_UP]     = !f1_first;
  assign present[lira_pkg::NB_LEFT]   = (f1_col != '0);
  assign present[lira_pkg::NB_UPLEFT] = (f1_col != '0) && !f1_first;

  always_comb begin
    for (int k = 0; k < lira_pkg::MASK_W; k++) begin
      hit[k] = f1_pixel && f1_pix.valid && present[k] && nb[k].valid &&
               lira_pkg::label_in_range(nb[k].label, MAX_REGIONS) &&
               (nb[k].label != f1_pix.label);
      diff[k] = (f1_pix.depth > nb[k].depth) ? (f1_pix.depth - nb[k].depth)
                                              : (nb[k].depth - f1_pix.depth);
      near[k] = hit[k] && (diff[k] < depth_threshold_mm);
    end
  end

  always_comb begin
    q_push.push                                = f1_done;
    q_push.entry.func                          = f1_func;
    q_push.entry.border                        = hit;
    q_push.entry.close_m                       = near;
    q_push.entry.label                         = f1_pix.label;
    q_push.entry.nb_label[lira_pkg::NB_UP]     = up_pix.label;
    q_push.entry.nb_label[lira_pkg::NB_LEFT]   = left_pix.label;
    q_push.entry.nb_label[lira_pkg::NB_UPLEFT] = ul_pix.label;
    q_push.entry.query_a                       = f1_qa;
    q_push.entry.query_b                       = f1_qb;
  end

endmodule

`default_nettype wire

/* sv/lira_queue.sv */
`default_nettype none

module lira_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lira_pkg::push_t in_push,
  output logic                 full,
  input  wire logic            pop,
  output lira_pkg::head_t      head
);

  localparam int PW = $clog2(lira_pkg::QUEUE_DEPTH);

  lira_pkg::entry_t slots [lira_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == (PW+1)'(lira_pkg::QUEUE_DEPTH));
  assign do_push    = in_push.push && !full;
  assign do_pop     = pop && (count != '0);
  assign head.avail = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/lira_back.sv */
`default_nettype none

module lira_back #(
  parameter int MAX_REGIONS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lira_pkg::head_t              head,
  output logic                              q_pop,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [lira_pkg::MASK_W-1:0]       border_mask,
  output logic [lira_pkg::MASK_W-1:0]       close_mask,
  output logic                              adjacent_2d,
  output logic                              adjacent_3d
);

  localparam int RW = $clog2(MAX_REGIONS);
  localparam int MW = 2 * MAX_REGIONS;

  typedef struct packed {
    logic                        wr;
    logic                        clear;
    logic                        query;
    logic                        emit;
    logic                        q_ok;
    logic                        close_b;
    logic [RW-1:0]               row;
    logic [RW-1:0]               col;
    logic [lira_pkg::MASK_W-1:0] border;
    logic [lira_pkg::MASK_W-1:0] close_m;
  } sub_t;

  // Issue side.
  logic [lira_pkg::MASK_W-1:0] done;
  logic [lira_pkg::MASK_W-1:0] pend;
  logic [1:0]                  sel;
  logic [lira_pkg::MASK_W-1:0] sel_onehot;
  logic [RW-1:0]               ia;
  logic [RW-1:0]               ib;
  logic                        sub_last;
  sub_t                        sub;
  logic                        s1_load;

  // Update stage.
  logic              s1_valid;
  sub_t              s1;
  logic              s1_done;
  logic              out_space;
  logic              out_valid;
  logic [MW-1:0]     rdata;
  logic [MW-1:0]     row_data;
  logic [MW-1:0]     new_row;
  logic [MAX_REGIONS-1:0] touch_row;
  logic [MAX_REGIONS-1:0] close_row;
  logic [MAX_REGIONS-1:0] bit_1h;
  logic [MAX_REGIONS-1:0] row_valid;
  logic              mat_we;
  logic              mfwd_hit;
  logic [MW-1:0]     mfwd_data;

  assign pend = head.entry.border & ~done;

  always_comb begin
    priority if (pend[lira_pkg::NB_UP]) begin
      sel = 2'(lira_pkg::NB_UP);
    end else if (pend[lira_pkg::NB_LEFT]) begin
      sel = 2'(lira_pkg::NB_LEFT);
    end else begin
      sel = 2'(lira_pkg::NB_UPLEFT);
    end
  end

  assign sel_onehot = lira_pkg::MASK_W'(1) << sel;

  always_comb begin
    ia       = '0;
    ib       = '0;
    sub_last = 1'b1;
    unique case (head.entry.func)
      lira_pkg::FUNC_PIXEL: begin
        ia       = head.entry.label[RW-1:0];
        ib       = head.entry.nb_label[sel][RW-1:0];
        sub_last = ((pend & ~sel_onehot) == '0);
      end
      lira_pkg::FUNC_QUERY: begin
        ia = head.entry.query_a[RW-1:0];
        ib = head.entry.query_b[RW-1:0];
      end
      lira_pkg::FUNC_START, lira_pkg::FUNC_NONE: begin
        ia = '0;
        ib = '0;
      end
    endcase
  end

  // The matrix is symmetric, so only the pair (smaller, larger) is stored.
  always_comb begin
    sub.wr      = (head.entry.func == lira_pkg::FUNC_PIXEL) && (pend != '0);
    sub.clear   = (head.entry.func == lira_pkg::FUNC_START);
    sub.query   = (head.entry.func == lira_pkg::FUNC_QUERY);
    sub.emit    = sub_last;
    sub.q_ok    = lira_pkg::label_in_range(head.entry.query_a, MAX_REGIONS) &&
                  lira_pkg::label_in_range(head.entry.query_b, MAX_REGIONS);
    sub.close_b = head.entry.close_m[sel];
    sub.row     = (ia < ib) ? ia : ib;
    sub.col     = (ia < ib) ? ib : ia;
    sub.border  = head.entry.border;
    sub.close_m = head.entry.close_m;
  end

  assign out_space = !out_valid || pop;
  assign s1_done   = s1_valid && (!s1.emit || out_space);
  assign s1_load   = head.avail && (!s1_valid || s1_done);
  assign q_pop     = s1_load && sub_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (s1_load) begin
      done <= sub_last ? '0 : (done | sel_onehot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= sub;
    end
  end

  // Read-modify-write of one matrix row per cycle, unless a waiting result holds the stage.
  assign mat_we = s1_done && s1.wr;

  lira_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_REGIONS)
  ) u_matrix (
    .clk  (clk),
    .we   (mat_we),
    .waddr(s1.row),
    .wdata(new_row),
    .re   (s1_load),
    .raddr(sub.row),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mfwd_hit <= 1'b0;
    end else if (s1_load) begin
      mfwd_hit <= mat_we && (s1.row == sub.row);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      mfwd_data <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (s1_done && s1.clear) begin
      row_valid <= '0;
    end else if (mat_we) begin
      row_valid[s1.row] <= 1'b1;
    end
  end

  assign row_data  = mfwd_hit ? mfwd_data : (row_valid[s1.row] ? rdata : '0);
  assign touch_row = row_data[MAX_REGIONS-1:0];
  assign close_row = row_data[MW-1:MAX_REGIONS];
  assign bit_1h    = MAX_REGIONS'(1) << s1.col;
  assign new_row   = {close_row | (s1.close_b ? bit_1h : '0), touch_row | bit_1h};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_done && s1.emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && s1.emit) begin
      border_mask <= s1.border;
      close_mask  <= s1.close_m;
      adjacent_2d <= s1.query && s1.q_ok && touch_row[s1.col];
      adjacent_3d <= s1.query && s1.q_ok && close_row[s1.col];
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

/* sv/label_image_region_adjacency_top.sv */
// Channel   Handshake             Beat contents
// -------   ---------             -------------
// input     push / full           func, label_valid, label, depth_mm, query_a, query_b
// result    empty / pop           border_mask, close_mask, adjacent_2d, adjacent_3d
// config    cfg_we (no wait)      cfg_index, cfg_data
//
// One input beat is taken per cycle while full is low. Pixel, frame-start and
// query beats pass the compare stage; the matrix update stage then handles one
// neighbor mark of a pixel (zero to three) at a time, and a pixel without marks
// or any other beat as a single step. Inside regions that is one beat per cycle
// while neither side stalls. On its way to the result ports a beat passes the
// compare register, the queue, the update stage and the result register.
// Reset needs no clearing pass: matrix rows carry valid bits, the line store is
// written before it is read. Either side may stall freely through the queue.
`default_nettype none

module label_image_region_adjacency_top #(
  parameter int MAX_REGIONS = 64,
  parameter int MAX_WIDTH   = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input beats.
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [lira_pkg::FUNC_W-1:0]         func,
  input  wire logic                                label_valid,
  input  wire logic [lira_pkg::LABEL_W-1:0]        label,
  input  wire logic [lira_pkg::DEPTH_W-1:0]        depth_mm,
  input  wire logic [lira_pkg::LABEL_W-1:0]        query_a,
  input  wire logic [lira_pkg::LABEL_W-1:0]        query_b,
  // Result beats.
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [lira_pkg::MASK_W-1:0]              border_mask,
  output logic [lira_pkg::MASK_W-1:0]              close_mask,
  output logic                                     adjacent_2d,
  output logic                                     adjacent_3d,
  // Configuration writes.
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [lira_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers. The user must change them only while the block is idle
  // (the block itself does not enforce this), so the front and back parts read them directly.
  logic [lira_pkg::WIDTH_W-1:0] image_width;
  logic [lira_pkg::DEPTH_W-1:0] depth_threshold_mm;

  // Links between the front part, the queue and the back part.
  lira_pkg::push_t q_push;
  logic            q_full;
  lira_pkg::head_t q_head;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width        <= lira_pkg::WIDTH_W'(640);
      depth_threshold_mm <= lira_pkg::DEPTH_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lira_pkg::REG_IMAGE_WIDTH:     image_width        <= cfg_data[lira_pkg::WIDTH_W-1:0];
        lira_pkg::REG_DEPTH_THRESHOLD: depth_threshold_mm <= cfg_data[lira_pkg::DEPTH_W-1:0];
      endcase
    end
  end

  // The front part tracks the raster position, reads the upper neighbor from the
  // line store, holds the left and upper-left pixels, and classifies each of the
  // three neighbors as a border and, with depth, as close.
  lira_front #(
    .MAX_REGIONS(MAX_REGIONS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .func              (func),
    .label_valid       (label_valid),
    .label             (label),
    .depth_mm          (depth_mm),
    .query_a           (query_a),
    .query_b           (query_b),
    .image_width       (image_width),
    .depth_threshold_mm(depth_threshold_mm),
    .q_full            (q_full),
    .q_push            (q_push)
  );

  // A short queue lets pixels keep flowing while the back part works through
  // a burst of neighbor marks.
  lira_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .in_push(q_push),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head)
  );

  // The back part sets matrix bits, clears the matrices on frame start, answers
  // queries and holds the result register that faces the result side.
  lira_back #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .border_mask(border_mask),
    .close_mask (close_mask),
    .adjacent_2d(adjacent_2d),
    .adjacent_3d(adjacent_3d)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default sizes; the predictor uses the same ones.
  localparam int NUM_REGIONS  = 64;
  localparam int LINE_LEN     = 1024;
  // Random beats (pixels, reads and frame starts) after the directed part.
  localparam int RANDOM_BEATS = 550;
  // Pixels in the long first row of a full-width frame.
  localparam int WIDE_PIXELS  = 300;
  // A few quiet cycles before a register write. Every mark of a beat is made
  // by the time its result appears, so the block is idle already.
  localparam int SETTLE_CYCLES = 8;
  // Cycles with no beat accepted on either side before the run is abandoned.
  localparam int IDLE_LIMIT   = 4000;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [lira_pkg::MASK_W-1:0] border;
    logic [lira_pkg::MASK_W-1:0] close_m;
    logic                        adj2;
    logic                        adj3;
  } adj_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input has a known value from time zero.
  logic                            push        = 1'b0;
  logic [lira_pkg::FUNC_W-1:0]     func        = lira_pkg::FUNC_NONE;
  logic                            label_valid = 1'b0;
  logic [lira_pkg::LABEL_W-1:0]    label       = '0;
  logic [lira_pkg::DEPTH_W-1:0]    depth_mm    = '0;
  logic [lira_pkg::LABEL_W-1:0]    query_a     = '0;
  logic [lira_pkg::LABEL_W-1:0]    query_b     = '0;
  logic                            pop         = 1'b0;
  logic                            cfg_we      = 1'b0;
  logic                            cfg_index   = lira_pkg::REG_IMAGE_WIDTH;
  logic [lira_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

  logic                        full;
  logic                        empty;
  logic [lira_pkg::MASK_W-1:0] border_mask;
  logic [lira_pkg::MASK_W-1:0] close_mask;
  logic                        adjacent_2d;
  logic                        adjacent_3d;

  label_image_region_adjacency_top #(
    .MAX_REGIONS(NUM_REGIONS),
    .MAX_WIDTH  (LINE_LEN)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .label_valid(label_valid),
    .label      (label),
    .depth_mm   (depth_mm),
    .query_a    (query_a),
    .query_b    (query_b),
    .empty      (empty),
    .pop        (pop),
    .border_mask(border_mask),
    .close_mask (close_mask),
    .adjacent_2d(adjacent_2d),
    .adjacent_3d(adjacent_3d),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, the line store, the two
  // delay registers, the raster position and both adjacency matrices.
  // ---------------------------------------------------------------------------
  logic [lira_pkg::WIDTH_W-1:0] width_reg;
  logic [lira_pkg::DEPTH_W-1:0] thresh_reg;
  logic [lira_pkg::LABEL_W:0]   label_store [LINE_LEN];
  logic [lira_pkg::DEPTH_W-1:0] depth_store [LINE_LEN];
  lira_pkg::pix_t               left_pix;
  lira_pkg::pix_t               upleft_pix;
  int unsigned                  col_pos;
  bit                           top_row;
  logic [NUM_REGIONS-1:0]       touch_rows [NUM_REGIONS];
  logic [NUM_REGIONS-1:0]       near_rows  [NUM_REGIONS];

  // Results owed by the block, oldest first.
  adj_result_t owed_results [$];

  // Stimulus shaping: a palette of regions per frame, each with a base depth.
  logic [lira_pkg::LABEL_W-1:0] palette [8];
  int                           palette_len;
  logic [lira_pkg::DEPTH_W-1:0] region_depth [NUM_REGIONS];
  // When set, neither side idles: a stretch at full rate.
  bit                           steady_flow = 1'b0;

  int counted_beats   = 0;
  int pixel_beats     = 0;
  int query_beats     = 0;
  int start_beats     = 0;
  int settings_used   = 0;
  int results_checked = 0;
  int touching_reads  = 0;
  int mismatches      = 0;

  // A new frame forgets all adjacency and restarts the raster at the top left.
  // The line store keeps its contents: the first row never reads it.
  function automatic void clear_frame();
    for (int r = 0; r < NUM_REGIONS; r++) begin
      touch_rows[r] = '0;
      near_rows[r]  = '0;
    end
    left_pix   = '0;
    upleft_pix = '0;
    col_pos    = 0;
    top_row    = 1'b1;
  endfunction

  function automatic void reset_predictor();
    width_reg  = 11'd640;
    thresh_reg = 16'd10;
    for (int c = 0; c < LINE_LEN; c++) begin
      label_store[c] = '0;
      depth_store[c] = '0;
    end
    clear_frame();
  endfunction

  // Compares the current pixel with one neighbor and marks both matrices.
  // Returns {close, border} for that neighbor position.
  function automatic logic [1:0] mark_neighbor(lira_pkg::pix_t cur, lira_pkg::pix_t nb,
                                               bit present);
    int unsigned diff;
    if (!present || !nb.valid || nb.label >= NUM_REGIONS || cur.label == nb.label)
      return 2'b00;
    touch_rows[cur.label][nb.label] = 1'b1;
    touch_rows[nb.label][cur.label] = 1'b1;
    diff = (cur.depth > nb.depth) ? cur.depth - nb.depth : nb.depth - cur.depth;
    if (diff < thresh_reg) begin
      near_rows[cur.label][nb.label] = 1'b1;
      near_rows[nb.label][cur.label] = 1'b1;
      return 2'b11;
    end
    return 2'b01;
  endfunction

  // Advances the predictor by one accepted input beat and returns its result.
  function automatic adj_result_t predict_adjacency(
    logic [lira_pkg::FUNC_W-1:0] fn, logic vld, logic [lira_pkg::LABEL_W-1:0] lab,
    logic [lira_pkg::DEPTH_W-1:0] dep, logic [lira_pkg::LABEL_W-1:0] qa,
    logic [lira_pkg::LABEL_W-1:0] qb);
    adj_result_t    res;
    int unsigned    w;
    int unsigned    c;
    bit             first;
    lira_pkg::pix_t cur;
    lira_pkg::pix_t up;
    logic [1:0]     hit;
    res = '0;
    case (fn)
      lira_pkg::FUNC_PIXEL: begin
        // A width of zero behaves as one; anything wider than the line store
        // behaves as the line store.
        w = width_reg;
        if (w == 0) w = 1;
        if (w > LINE_LEN) w = LINE_LEN;
        c = (col_pos >= LINE_LEN) ? LINE_LEN - 1 : col_pos;
        first = top_row;
        cur = '0;
        if (vld && lab < NUM_REGIONS) begin
          cur.depth = dep;
          cur.valid = 1'b1;
          cur.label = lab;
        end
        up = {depth_store[c], label_store[c]};
        // An unlabelled pixel is stored but never compared.
        if (cur.valid) begin
          hit = mark_neighbor(cur, up, !first);
          res.border[lira_pkg::NB_UP] = hit[0];
          res.close_m[lira_pkg::NB_UP] = hit[1];
          hit = mark_neighbor(cur, left_pix, c > 0);
          res.border[lira_pkg::NB_LEFT] = hit[0];
          res.close_m[lira_pkg::NB_LEFT] = hit[1];
          hit = mark_neighbor(cur, upleft_pix, c > 0 && !first);
          res.border[lira_pkg::NB_UPLEFT] = hit[0];
          res.close_m[lira_pkg::NB_UPLEFT] = hit[1];
        end
        upleft_pix = first ? lira_pkg::pix_t'('0) : up;
        left_pix = cur;
        label_store[c] = {cur.valid, cur.label};
        depth_store[c] = dep;
        // The row ends at the last column; the delay registers empty out.
        if (c + 1 >= w) begin
          col_pos    = 0;
          top_row    = 1'b0;
          left_pix   = '0;
          upleft_pix = '0;
        end else begin
          col_pos = c + 1;
        end
      end
      lira_pkg::FUNC_START: clear_frame();
      lira_pkg::FUNC_QUERY: begin
        if (qa < NUM_REGIONS && qb < NUM_REGIONS) begin
          res.adj2 = touch_rows[qa][qb];
          res.adj3 = near_rows[qa][qb];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Gap lengths for both sides: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [lira_pkg::LABEL_W-1:0] pick_region();
    if ($urandom_range(0, 4) != 0) return palette[$urandom_range(0, palette_len - 1)];
    return lira_pkg::LABEL_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Fields change at the falling edge; a beat counts when push is
  // high and full is low at the rising edge. push stays high between
  // back-to-back beats, so it is never lowered and raised in one time step.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [lira_pkg::FUNC_W-1:0] fn, input logic vld,
                           input logic [lira_pkg::LABEL_W-1:0] lab,
                           input logic [lira_pkg::DEPTH_W-1:0] dep,
                           input logic [lira_pkg::LABEL_W-1:0] qa,
                           input logic [lira_pkg::LABEL_W-1:0] qb);
    int          gap;
    adj_result_t owed;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push        <= 1'b1;
    func        <= fn;
    label_valid <= vld;
    label       <= lab;
    depth_mm    <= dep;
    query_a     <= qa;
    query_b     <= qb;
    @(posedge clk);
    while (full) @(posedge clk);
    owed = predict_adjacency(fn, vld, lab, dep, qa, qb);
    owed_results = {owed_results, owed};
    case (fn)
      lira_pkg::FUNC_PIXEL: pixel_beats++;
      lira_pkg::FUNC_QUERY: query_beats++;
      lira_pkg::FUNC_START: start_beats++;
      default: ;
    endcase
    if (fn != lira_pkg::FUNC_NONE) counted_beats++;
  endtask

  // Pixel beats carry random values in the read fields, which must be ignored.
  task automatic send_pixel(input logic vld, input logic [lira_pkg::LABEL_W-1:0] lab,
                            input logic [lira_pkg::DEPTH_W-1:0] dep);
    send_beat(lira_pkg::FUNC_PIXEL, vld, lab, dep, lira_pkg::LABEL_W'($urandom),
              lira_pkg::LABEL_W'($urandom));
  endtask

  task automatic send_query(input logic [lira_pkg::LABEL_W-1:0] qa,
                            input logic [lira_pkg::LABEL_W-1:0] qb);
    send_beat(lira_pkg::FUNC_QUERY, 1'($urandom), lira_pkg::LABEL_W'($urandom),
              lira_pkg::DEPTH_W'($urandom), qa, qb);
  endtask

  // Frame starts and the unused code, with noise in every field.
  task automatic send_control(input logic [lira_pkg::FUNC_W-1:0] fn);
    send_beat(fn, 1'($urandom), lira_pkg::LABEL_W'($urandom), lira_pkg::DEPTH_W'($urandom),
              lira_pkg::LABEL_W'($urandom), lira_pkg::LABEL_W'($urandom));
  endtask

  task automatic sender_rest();
    @(negedge clk);
    push <= 1'b0;
  endtask

  // The sender holds off until every owed result has been read out, then
  // waits a few more quiet cycles.
  task automatic settle_block();
    sender_rest();
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_register(input logic idx,
                                input logic [lira_pkg::CFG_DATA_W-1:0] data);
    settle_block();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == lira_pkg::REG_IMAGE_WIDTH) width_reg = data[lira_pkg::WIDTH_W-1:0];
    else thresh_reg = data;
  endtask

  task automatic new_palette();
    logic [lira_pkg::DEPTH_W-1:0] base;
    base = lira_pkg::DEPTH_W'($urandom);
    palette_len = $urandom_range(2, 8);
    for (int i = 0; i < palette_len; i++) begin
      palette[i] = lira_pkg::LABEL_W'($urandom);
      region_depth[palette[i]] = base + lira_pkg::DEPTH_W'($urandom_range(0, 40));
    end
  endtask

  // One frame in raster order: runs of regions along each row, a few
  // unlabelled pixels and wild depths, with reads and ignored beats mixed in.
  task automatic stream_frame(input int n_pixels, input bit allow_restart);
    int                           done_pixels;
    int                           roll;
    logic [lira_pkg::LABEL_W-1:0] run_label;
    logic [lira_pkg::DEPTH_W-1:0] dep;
    done_pixels = 0;
    run_label = palette[0];
    send_control(lira_pkg::FUNC_START);
    while (done_pixels < n_pixels) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_query(pick_region(), pick_region());
      end else if (roll < 10) begin
        send_control(lira_pkg::FUNC_NONE);
      end else if (roll == 10 && allow_restart) begin
        send_control(lira_pkg::FUNC_START);
      end else begin
        if ($urandom_range(0, 3) == 0) run_label = palette[$urandom_range(0, palette_len - 1)];
        if ($urandom_range(0, 19) == 0) dep = lira_pkg::DEPTH_W'($urandom);
        else dep = region_depth[run_label] + lira_pkg::DEPTH_W'($urandom_range(0, 12));
        send_pixel($urandom_range(0, 9) != 0, run_label, dep);
        done_pixels++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------

  // Reset values: a 640-pixel row and a threshold of 10 mm. Only the left
  // neighbor exists in the first row; a difference of exactly the threshold
  // is not close.
  task automatic test_reset_defaults();
    settings_used++;
    send_pixel(1'b1, 6'd5, 16'd1000);
    send_pixel(1'b1, 6'd6, 16'd1005);
    send_pixel(1'b1, 6'd6, 16'd1020);
    send_pixel(1'b1, 6'd7, 16'd1010);
    send_pixel(1'b0, 6'd9, 16'd0);
    send_pixel(1'b1, 6'd8, 16'd0);
    send_query(6'd5, 6'd6);
    send_query(6'd6, 6'd5);
    send_query(6'd6, 6'd7);
    send_query(6'd7, 6'd7);
    send_control(lira_pkg::FUNC_NONE);
  endtask

  // Extreme labels and depths, the widest threshold, a zero threshold and a
  // zero width, which makes every pixel a row of its own.
  task automatic test_extreme_values();
    write_register(lira_pkg::REG_IMAGE_WIDTH, 16'd2);
    write_register(lira_pkg::REG_DEPTH_THRESHOLD, 16'hFFFF);
    settings_used++;
    send_control(lira_pkg::FUNC_START);
    send_pixel(1'b1, 6'd0, 16'h0000);
    send_pixel(1'b1, 6'd63, 16'hFFFF);
    send_pixel(1'b1, 6'd63, 16'h0000);
    send_pixel(1'b1, 6'd0, 16'hFFFF);
    send_query(6'd0, 6'd63);
    send_query(6'd63, 6'd0);

    write_register(lira_pkg::REG_DEPTH_THRESHOLD, 16'd0);
    settings_used++;
    send_control(lira_pkg::FUNC_START);
    send_pixel(1'b1, 6'd1, 16'd7);
    send_pixel(1'b1, 6'd2, 16'd7);
    send_query(6'd1, 6'd2);

    write_register(lira_pkg::REG_IMAGE_WIDTH, 16'd0);
    write_register(lira_pkg::REG_DEPTH_THRESHOLD, 16'd50);
    settings_used++;
    send_control(lira_pkg::FUNC_START);
    send_pixel(1'b1, 6'd3, 16'd100);
    send_pixel(1'b1, 6'd4, 16'd120);
    send_pixel(1'b1, 6'd3, 16'd100);
    send_query(6'd3, 6'd4);
  endtask

  // A long first row of a wide frame: the column counter runs far past any
  // width that the random frames use.
  task automatic test_wide_rows(input logic [lira_pkg::WIDTH_W-1:0] w);
    write_register(lira_pkg::REG_IMAGE_WIDTH, lira_pkg::CFG_DATA_W'(w));
    write_register(lira_pkg::REG_DEPTH_THRESHOLD,
                   lira_pkg::CFG_DATA_W'($urandom_range(5, 30)));
    settings_used++;
    new_palette();
    stream_frame(WIDE_PIXELS, 1'b0);
  endtask

  // Many short frames, each under fresh register settings, some at full rate.
  task automatic test_random_frames();
    int                              first_count;
    int                              eff_w;
    logic [lira_pkg::WIDTH_W-1:0]    w;
    logic [lira_pkg::CFG_DATA_W-1:0] thr;
    first_count = counted_beats;
    while (counted_beats - first_count < RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0: w = 11'd0;
        1: w = 11'd1;
        2: w = lira_pkg::WIDTH_W'($urandom_range(17, 80));
        default: w = lira_pkg::WIDTH_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 7))
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = lira_pkg::CFG_DATA_W'($urandom);
        default: thr = lira_pkg::CFG_DATA_W'($urandom_range(1, 24));
      endcase
      write_register(lira_pkg::REG_IMAGE_WIDTH, lira_pkg::CFG_DATA_W'(w));
      write_register(lira_pkg::REG_DEPTH_THRESHOLD, thr);
      settings_used++;
      steady_flow = ($urandom_range(0, 3) == 0);
      new_palette();
      eff_w = (w == 0) ? 1 : int'(w);
      stream_frame($urandom_range(1, 5) * eff_w + $urandom_range(0, eff_w), 1'b1);
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side. pop changes at the falling edge with random stalls; each
  // result beat is taken at the rising edge and checked against the oldest
  // owed result.
  // ---------------------------------------------------------------------------
  int pop_stall = 0;

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_stall = 0;
    end else if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else begin
      pop <= 1'b1;
      if (!steady_flow && $urandom_range(0, 5) == 0) pop_stall = pick_gap();
    end
  end

  always @(posedge clk) begin : check_result
    adj_result_t seen;
    adj_result_t want;
    if (!rst && pop && !empty) begin
      seen = {border_mask, close_mask, adjacent_2d, adjacent_3d};
      results_checked++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat at %0t with nothing owed: border %b close %b 2d %b 3d %b",
                   $time, seen.border, seen.close_m, seen.adj2, seen.adj3);
      end else begin
        want = owed_results.pop_front();
        if (want.adj2) touching_reads++;
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: expected border %b close %b 2d %b 3d %b,",
                      " got border %b close %b 2d %b 3d %b"},
                     $time, want.border, want.close_m, want.adj2, want.adj3,
                     seen.border, seen.close_m, seen.adj2, seen.adj3);
        end
      end
    end
  end

  // Watchdog: gives up when neither side has moved a beat for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, then each test in turn, then drain and report.
  // ---------------------------------------------------------------------------
  initial begin
    reset_predictor();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_extreme_values();
    test_wide_rows(11'd1024);
    test_random_frames();

    sender_rest();
    while (owed_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (owed_results.size() != 0) mismatches++;

    $display("summary: %0d pixel, %0d read and %0d frame-start beats under %0d settings",
             pixel_beats, query_beats, start_beats, settings_used);
    $display("summary: %0d results checked, %0d reads found touching regions, %0d mismatches",
             results_checked, touching_reads, mismatches);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
